// ===== rtl/core/tasam_pkg.sv =====
// shared types and constants of the axis-swap address map
// no dependencies; used by every module of the block
`default_nettype none

package tasam_pkg;

	localparam int unsigned EXT_REGS = 4;
	localparam int unsigned EXT_W = 16;
	localparam int unsigned IDX_W = 32;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned DIV_BITS = 4;
	localparam int unsigned DIV_STAGES_PER_AXIS = IDX_W / DIV_BITS;
	localparam int unsigned DIV_AXES = EXT_REGS - 1;
	localparam int unsigned DIV_STAGES = DIV_AXES * DIV_STAGES_PER_AXIS;
	localparam int unsigned CNT_W = IDX_W + 1;

	typedef enum logic [2:0] {
		REG_NUM_AXES = 3'd0,
		REG_SWAP_A   = 3'd1,
		REG_SWAP_B   = 3'd2,
		REG_EXTENT_0 = 3'd3,
		REG_EXTENT_1 = 3'd4,
		REG_EXTENT_2 = 3'd5,
		REG_EXTENT_3 = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]  elem_index;
		logic [WORD_W-1:0] elem_word;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  dest_offset;
		logic [WORD_W-1:0] word_out;
		logic              in_range;
	} out_item_t;

	typedef struct packed {
		logic [2:0]                         num_axes;
		logic [1:0]                         swap_axis_a;
		logic [1:0]                         swap_axis_b;
		logic [EXT_REGS-1:0][EXT_W-1:0]     extent;
	} cfg_t;

	typedef struct packed {
		logic [EXT_REGS-1:0][EXT_W-1:0]     ext_eff;
		logic [EXT_REGS-1:0][IDX_W-1:0]     out_stride;
		logic [CNT_W-1:0]                   count;
		logic                               do_swap;
		logic [1:0]                         axis_a;
		logic [1:0]                         axis_b;
	} geom_t;

	typedef struct packed {
		logic [IDX_W-1:0]                   idx;
		logic [WORD_W-1:0]                  word;
		logic [EXT_W-1:0]                   rem;
		logic [IDX_W-1:0]                   quo;
		logic [EXT_REGS-1:0][EXT_W-1:0]     coord;
	} pipe_t;

endpackage

`default_nettype wire

// ===== rtl/core/tasam_geom.sv =====
// derived geometry: effective extents, output strides, element count
// depends on tasam_pkg
`default_nettype none

module tasam_geom import tasam_pkg::*; #(
	parameter int unsigned AXES_LIM = 4
) (
	input  wire logic  clk,
	input  wire cfg_t  cfg,
	output geom_t      geom
);

	logic [2:0]                     n_c;
	logic [EXT_REGS-1:0][EXT_W-1:0] eff_c;
	logic [EXT_REGS-1:0][EXT_W-1:0] oext_c;
	logic                           swap_c;

	logic [EXT_REGS-1:0][EXT_W-1:0] eff_s1;
	logic [EXT_REGS-1:0][EXT_W-1:0] oext_s1;
	logic                           swap_s1;
	logic [1:0]                     a_s1;
	logic [1:0]                     b_s1;

	logic [IDX_W-1:0]               o23_s2;
	logic [IDX_W-1:0]               c01_s2;
	logic [IDX_W-1:0]               c23_s2;
	logic [EXT_W-1:0]               oe1_s2;
	logic [EXT_W-1:0]               oe3_s2;

	logic [IDX_W-1:0]               ostr0_s3;
	logic [IDX_W-1:0]               o23_s3;
	logic [EXT_W-1:0]               oe3_s3;
	logic [2*IDX_W-1:0]             cnt_s3;

	logic [CNT_W-1:0]               cnt_s4;
	logic [IDX_W+EXT_W-1:0]         ostr0_full;

	always_comb begin
		n_c = (cfg.num_axes == 3'd0) ? 3'd1 : cfg.num_axes;
		if (n_c > 3'(AXES_LIM)) begin
			n_c = 3'(AXES_LIM);
		end
		swap_c = ({1'b0, cfg.swap_axis_a} < n_c) && ({1'b0, cfg.swap_axis_b} < n_c);
		for (int i = 0; i < EXT_REGS; i++) begin
			eff_c[i] = (3'(i) < n_c) ? cfg.extent[i] : EXT_W'(1);
		end
		oext_c = eff_c;
		if (swap_c) begin
			oext_c[cfg.swap_axis_a] = eff_c[cfg.swap_axis_b];
			oext_c[cfg.swap_axis_b] = eff_c[cfg.swap_axis_a];
		end
		ostr0_full = {{EXT_W{1'b0}}, o23_s2} * {{IDX_W{1'b0}}, oe1_s2};
	end

	always_ff @(posedge clk) begin
		eff_s1   <= eff_c;
		oext_s1  <= oext_c;
		swap_s1  <= swap_c;
		a_s1     <= cfg.swap_axis_a;
		b_s1     <= cfg.swap_axis_b;

		o23_s2   <= {{EXT_W{1'b0}}, oext_s1[2]} * {{EXT_W{1'b0}}, oext_s1[3]};
		c01_s2   <= {{EXT_W{1'b0}}, eff_s1[0]} * {{EXT_W{1'b0}}, eff_s1[1]};
		c23_s2   <= {{EXT_W{1'b0}}, eff_s1[2]} * {{EXT_W{1'b0}}, eff_s1[3]};
		oe1_s2   <= oext_s1[1];
		oe3_s2   <= oext_s1[3];

		ostr0_s3 <= ostr0_full[IDX_W-1:0];
		o23_s3   <= o23_s2;
		oe3_s3   <= oe3_s2;
		cnt_s3   <= {{IDX_W{1'b0}}, c01_s2} * {{IDX_W{1'b0}}, c23_s2};

		// element count saturates at 2^32
		cnt_s4   <= (cnt_s3 > {{(IDX_W-1){1'b0}}, 1'b1, {IDX_W{1'b0}}})
			? {1'b1, {IDX_W{1'b0}}} : cnt_s3[CNT_W-1:0];
	end

	always_comb begin
		geom.ext_eff       = eff_s1;
		geom.out_stride[3] = IDX_W'(1);
		geom.out_stride[2] = {{(IDX_W-EXT_W){1'b0}}, oe3_s3};
		geom.out_stride[1] = o23_s3;
		geom.out_stride[0] = ostr0_s3;
		geom.count         = cnt_s4;
		geom.do_swap       = swap_s1;
		geom.axis_a        = a_s1;
		geom.axis_b        = b_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tasam_div_stage.sv =====
// one stage of the pipelined restoring divider, DIV_BITS (4) quotient bits per stage
// depends on tasam_pkg
`default_nettype none

module tasam_div_stage import tasam_pkg::*; #(
	parameter bit          LAST = 1'b0,
	parameter int unsigned AXIS = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire pipe_t             pipe_in,
	input  wire logic [EXT_W-1:0]  divisor,
	output logic                   valid_out,
	output pipe_t                  pipe_out
);

	localparam logic [1:0] AX = 2'(AXIS);

	logic [EXT_W:0]   t;
	logic [EXT_W-1:0] r;
	logic [IDX_W-1:0] q;
	pipe_t            nxt;

	always_comb begin
		r = pipe_in.rem;
		q = pipe_in.quo;
		t = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r, q[IDX_W-1]};
			q = {q[IDX_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				q[0] = 1'b1;
			end
			r = t[EXT_W-1:0];
		end
		nxt = pipe_in;
		nxt.quo = q;
		nxt.rem = r;
		if (LAST) begin
			// remainder is this axis's coordinate, quotient feeds the next axis
			nxt.coord[AX] = r;
			nxt.rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_out <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tasam_dot.sv =====
// coordinate exchange, range check and dot product with output strides
// depends on tasam_pkg
`default_nettype none

module tasam_dot import tasam_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid_in,
	input  wire pipe_t  pipe_in,
	input  wire geom_t  geom,
	output logic        valid_out,
	output out_item_t   item_out
);

	logic [EXT_REGS-1:0][EXT_W-1:0] c_c;
	logic [EXT_REGS-1:0][EXT_W-1:0] sw_c;
	logic [EXT_REGS-1:0][IDX_W+EXT_W-1:0] prod_c;

	logic [EXT_REGS-1:0][EXT_W-1:0] sw_s1;
	logic                           rng_s1;
	logic [WORD_W-1:0]              word_s1;
	logic                           v_s1;

	logic [EXT_REGS-1:0][IDX_W-1:0] prod_s2;
	logic                           rng_s2;
	logic [WORD_W-1:0]              word_s2;
	logic                           v_s2;

	logic [IDX_W-1:0]               lo_s3;
	logic [IDX_W-1:0]               hi_s3;
	logic                           rng_s3;
	logic [WORD_W-1:0]              word_s3;
	logic                           v_s3;

	always_comb begin
		c_c = pipe_in.coord;
		c_c[0] = pipe_in.quo[EXT_W-1:0];
		for (int i = 0; i < EXT_REGS; i++) begin
			if (geom.do_swap && (2'(i) == geom.axis_a)) begin
				sw_c[i] = c_c[geom.axis_b];
			end else if (geom.do_swap && (2'(i) == geom.axis_b)) begin
				sw_c[i] = c_c[geom.axis_a];
			end else begin
				sw_c[i] = c_c[i];
			end
			prod_c[i] = {{IDX_W{1'b0}}, sw_s1[i]} * {{EXT_W{1'b0}}, geom.out_stride[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			v_s1      <= valid_in;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			valid_out <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s1   <= sw_c;
			rng_s1  <= {1'b0, pipe_in.idx} < geom.count;
			word_s1 <= pipe_in.word;

			for (int i = 0; i < EXT_REGS; i++) begin
				prod_s2[i] <= prod_c[i][IDX_W-1:0];
			end
			rng_s2  <= rng_s1;
			word_s2 <= word_s1;

			lo_s3   <= prod_s2[0] + prod_s2[1];
			hi_s3   <= prod_s2[2] + prod_s2[3];
			rng_s3  <= rng_s2;
			word_s3 <= word_s2;

			item_out.dest_offset <= rng_s3 ? (lo_s3 + hi_s3) : '0;
			item_out.word_out    <= word_s3;
			item_out.in_range    <= rng_s3;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tensor_axis_swap_address_map.sv =====
// Axis-swap address map: takes one element (linear row-major index and data word) per
// cycle and returns its offset in the array with two axes exchanged, one result per
// cycle at full rate unless out_ready stalls it. The pipeline is 24 divider stages
// (three axis divisions of 4 quotient bits per stage) plus 4 stages for exchange,
// multiply and sum. The whole pipeline advances together and halts while a result
// waits on out_ready. tasam_geom registers the derived strides and element count.
// depends on tasam_pkg, tasam_geom, tasam_div_stage, tasam_dot
`default_nettype none

module tensor_axis_swap_address_map import tasam_pkg::*; #(
	parameter int unsigned MAX_AXES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned AXES_LIM = (MAX_AXES < EXT_REGS) ? MAX_AXES : EXT_REGS;

	cfg_t  cfg_q;
	geom_t geom;
	logic  en;

	logic  [DIV_STAGES:0] v;
	pipe_t                p [DIV_STAGES+1];

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_axes    <= 3'd1;
			cfg_q.swap_axis_a <= 2'd0;
			cfg_q.swap_axis_b <= 2'd0;
			for (int i = 0; i < EXT_REGS; i++) begin
				cfg_q.extent[i] <= EXT_W'(1);
			end
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_AXES: cfg_q.num_axes    <= cfg_data[2:0];
				REG_SWAP_A:   cfg_q.swap_axis_a <= cfg_data[1:0];
				REG_SWAP_B:   cfg_q.swap_axis_b <= cfg_data[1:0];
				REG_EXTENT_0: cfg_q.extent[0]   <= cfg_data;
				REG_EXTENT_1: cfg_q.extent[1]   <= cfg_data;
				REG_EXTENT_2: cfg_q.extent[2]   <= cfg_data;
				REG_EXTENT_3: cfg_q.extent[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	tasam_geom #(
		.AXES_LIM(AXES_LIM)
	) u_geom (
		.clk  (clk),
		.cfg  (cfg_q),
		.geom (geom)
	);

	always_comb begin
		v[0]         = in_valid;
		p[0].idx     = in_data.elem_index;
		p[0].word    = in_data.elem_word;
		p[0].rem     = '0;
		p[0].quo     = in_data.elem_index;
		p[0].coord   = '0;
	end

	// innermost axis first; padded axes divide by one
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int unsigned AXIS = EXT_REGS - 1 - g / DIV_STAGES_PER_AXIS;
		localparam bit LAST = (g % DIV_STAGES_PER_AXIS) == DIV_STAGES_PER_AXIS - 1;
		tasam_div_stage #(
			.LAST (LAST),
			.AXIS (AXIS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (v[g]),
			.pipe_in   (p[g]),
			.divisor   (geom.ext_eff[AXIS]),
			.valid_out (v[g+1]),
			.pipe_out  (p[g+1])
		);
	end

	tasam_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v[DIV_STAGES]),
		.pipe_in   (p[DIV_STAGES]),
		.geom      (geom),
		.valid_out (out_valid),
		.item_out  (out_data)
	);

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_range |-> out_data.dest_offset == '0)
		else $error("out-of-range result with nonzero offset");

	a_cfg_axes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_NUM_AXES |=> cfg_q.num_axes == $past(cfg_data[2:0]))
		else $error("axis count write lost");

	// stage valids only; the input valid may rise during a stall
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v[DIV_STAGES:1]))
		else $error("pipeline moved during stall");

	a_swap_axes: assert property (@(posedge clk) disable iff (!arst_n)
		geom.do_swap |-> geom.ext_eff[geom.axis_a] == cfg_q.extent[geom.axis_a]
			|| $past(cfg_valid))
		else $error("swap on a padded axis");

endmodule

`default_nettype wire
